[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands for the race detector checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked on clk, quiet while arst_n is low
`define CARD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent in this cycle, consequent in the next
`define CARD_ASSERT_NEXT(label, pre, post, msg) \
	`CARD_ASSERT(label, (pre) |=> (post), msg)

`endif

[rtl/card_pkg.sv]
// ----------------------------------------------------------------------------
// card_pkg
// shared types, codes and defaults of the concurrent access race detector
// ----------------------------------------------------------------------------
`default_nettype none

package card_pkg;

	localparam int DEFAULT_TABLE_ENTRIES = 16;
	localparam int DEFAULT_THREAD_BITS   = 8;

	// event codes
	localparam logic [1:0] OP_BEFORE_READ  = 2'd0;
	localparam logic [1:0] OP_BEFORE_WRITE = 2'd1;
	localparam logic [1:0] OP_AFTER_ACCESS = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  thread_id;
		logic [63:0] address;
	} req_t;

	typedef struct packed {
		logic       race_found;
		logic [7:0] prior_thread;
		logic       prior_was_write;
		logic       recorded;
		logic       removed;
		logic       overflow;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic issue;
		logic commit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last_issue;
		logic out_ready;
	} sts_t;

endpackage

`default_nettype wire

[rtl/card_ctrl.sv]
// ----------------------------------------------------------------------------
// card_ctrl
// sequencer: accept an item, sweep the table, commit the result
// ----------------------------------------------------------------------------
`default_nettype none

module card_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire card_pkg::sts_t sts,
	output card_pkg::cmd_t     cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign req_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
				if (sts.last_issue) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_ready) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

[rtl/card_dpath.sv]
// ----------------------------------------------------------------------------
// card_dpath
// access table memory, valid bits, sweep compare and result register
// ----------------------------------------------------------------------------
`default_nettype none

module card_dpath #(
	parameter int TABLE_ENTRIES = card_pkg::DEFAULT_TABLE_ENTRIES,
	parameter int THREAD_BITS   = card_pkg::DEFAULT_THREAD_BITS
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire card_pkg::req_t req,
	output card_pkg::rsp_t     rsp,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	input  wire card_pkg::cmd_t cmd,
	output card_pkg::sts_t     sts
);

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int TW = THREAD_BITS;
	localparam int EW = 64 + TW + 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

	// entry layout: address, thread, write flag
	logic [EW-1:0]            mem_q [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;

	card_pkg::req_t req_q;
	logic [IW-1:0]  rd_idx_q;
	logic           cmp_vld_s1;
	logic [IW-1:0]  cmp_idx_s1;
	logic [EW-1:0]  rd_data_s1;

	logic           hit_q;
	logic [IW-1:0]  hit_idx_q;
	logic [TW-1:0]  hit_thr_q;
	logic           hit_wr_q;
	logic           free_q;
	logic [IW-1:0]  free_idx_q;

	card_pkg::rsp_t rsp_q;
	logic           rsp_valid_q;

	logic [TW+7:0]  tid_ext;
	logic [TW-1:0]  tid;
	logic [TW+7:0]  prior_ext;
	logic           is_write;
	logic [63:0]    ent_addr;
	logic [TW-1:0]  ent_thr;
	logic           ent_wr;
	logic           ent_valid;
	logic           ins_en;
	logic           rem_en;
	card_pkg::rsp_t rsp_d;

	assign tid_ext   = {{TW{1'b0}}, req_q.thread_id};
	assign tid       = tid_ext[TW-1:0];
	assign prior_ext = {8'b0, hit_thr_q};
	assign is_write  = (req_q.operation == card_pkg::OP_BEFORE_WRITE);

	assign ent_addr  = rd_data_s1[EW-1 -: 64];
	assign ent_thr   = rd_data_s1[TW:1];
	assign ent_wr    = rd_data_s1[0];
	assign ent_valid = valid_q[cmp_idx_s1];

	assign sts.last_issue = (rd_idx_q == LAST_IDX);
	assign sts.out_ready  = !rsp_valid_q || !rsp_stall;

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	// result and table update for the item held in req_q
	always_comb begin
		rsp_d  = '0;
		ins_en = 1'b0;
		rem_en = 1'b0;
		case (req_q.operation)
			card_pkg::OP_BEFORE_READ, card_pkg::OP_BEFORE_WRITE: begin
				if (hit_q) begin
					rsp_d.race_found      = hit_wr_q | is_write;
					rsp_d.prior_thread    = prior_ext[7:0];
					rsp_d.prior_was_write = hit_wr_q;
				end else if (free_q) begin
					ins_en         = 1'b1;
					rsp_d.recorded = 1'b1;
				end else begin
					rsp_d.overflow = 1'b1;
				end
			end
			card_pkg::OP_AFTER_ACCESS: begin
				if (hit_q && (hit_thr_q == tid)) begin
					rem_en        = 1'b1;
					rsp_d.removed = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && ins_en) begin
			mem_q[free_idx_q] <= {req_q.address, tid, is_write};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			rd_data_s1 <= mem_q[rd_idx_q];
		end
		cmp_idx_s1 <= rd_idx_q;
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.commit) begin
			rsp_q <= rsp_d;
		end
		if (cmp_vld_s1 && ent_valid && (ent_addr == req_q.address) && !hit_q) begin
			hit_idx_q <= cmp_idx_s1;
			hit_thr_q <= ent_thr;
			hit_wr_q  <= ent_wr;
		end
		if (cmp_vld_s1 && !ent_valid && !free_q) begin
			free_idx_q <= cmp_idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_idx_q    <= '0;
			cmp_vld_s1  <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			cmp_vld_s1 <= cmd.issue;
			if (cmd.load) begin
				rd_idx_q <= '0;
				hit_q    <= 1'b0;
				free_q   <= 1'b0;
			end else begin
				if (cmd.issue) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
				if (cmp_vld_s1 && ent_valid && (ent_addr == req_q.address)) begin
					hit_q <= 1'b1;
				end
				if (cmp_vld_s1 && !ent_valid) begin
					free_q <= 1'b1;
				end
			end
			if (cmd.commit && ins_en) begin
				valid_q[free_idx_q] <= 1'b1;
			end
			if (cmd.commit && rem_en) begin
				valid_q[hit_idx_q] <= 1'b0;
			end
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/concurrent_access_race_detector.sv]
// ----------------------------------------------------------------------------
// concurrent_access_race_detector
// table of accesses in progress, flags racing accesses where one is a write
// ----------------------------------------------------------------------------
// usage
//   req channel (req_valid, req_stall, req): one memory access event per item,
//     before read, before write or after access, with thread and address
//   rsp channel (rsp_valid, rsp_stall, rsp): exactly one result item per event
//   an item is taken at a clock edge with valid high and stall low
// sweep
//   the table lives in a one-port memory swept one entry a cycle, so a new item
//   is accepted only after the sweep, drain and commit of the last one; the
//   result is registered in the output register at commit
// reset
//   arst_n clears every valid bit at once, so the table starts empty with no
//   clearing pass; entry contents are only looked at behind a valid bit
// receiver stall
//   the result waits in the output register; a new item is still accepted and
//   swept, and its commit waits until the output register frees up
// ----------------------------------------------------------------------------
`default_nettype none

module concurrent_access_race_detector #(
	parameter int TABLE_ENTRIES = card_pkg::DEFAULT_TABLE_ENTRIES,
	parameter int THREAD_BITS   = card_pkg::DEFAULT_THREAD_BITS
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire card_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output card_pkg::rsp_t     rsp
);

	// command and status between the sequencer and the datapath
	card_pkg::cmd_t cmd;
	card_pkg::sts_t sts;

	// sequencer: idle, sweep, drain the read pipe, commit
	card_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// table memory, valid bits, compare and result register
	card_dpath #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.THREAD_BITS   (THREAD_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

`default_nettype wire

[rtl/card_checker.sv]
// ----------------------------------------------------------------------------
// card_checker
// port level checks of the race detector, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module card_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_stall,
	input wire logic           rsp_valid,
	input wire logic           rsp_stall,
	input wire card_pkg::rsp_t rsp
);

	logic [3:0] outcome_bits;
	logic       prior_clear;

	assign outcome_bits = {rsp.race_found, rsp.recorded, rsp.removed, rsp.overflow};
	assign prior_clear  = (rsp.prior_thread == 8'd0) && !rsp.prior_was_write;

	`CARD_ASSERT_NEXT(a_rsp_valid_held, rsp_valid && rsp_stall, rsp_valid, "rsp valid dropped")
	`CARD_ASSERT_NEXT(a_rsp_data_held, rsp_valid && rsp_stall, $stable(rsp), "rsp changed")
	`CARD_ASSERT_NEXT(a_one_at_a_time, req_valid && !req_stall, req_stall, "item overlap")
	`CARD_ASSERT(a_one_outcome, !rsp_valid || $onehot0(outcome_bits), "outcomes mixed")
	`CARD_ASSERT(a_removed_clean, !(rsp_valid && rsp.removed) || prior_clear, "removal with prior")

endmodule

bind concurrent_access_race_detector card_checker u_card_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire
